FILE: src/sflm_pkg.sv
// ----------------------------------------------------------------------------
// Segregated free list manager package
// Field widths, operation and status codes, control structs and the size
// class table shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package sflm_pkg;

  // Fixed field widths of the request and response words
  localparam int SIZE_W   = 16;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 3;
  localparam int CLASS_W  = 4;
  localparam int TOTAL_W  = 12;

  // Width of a class byte size (largest class is 1 << 19)
  localparam int CB_W = 20;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Smallest class and the shift that places class 1 at 32 bytes
  localparam logic [CB_W-1:0]    MIN_CLASS_BYTES = 20'd24;
  localparam logic [CLASS_W:0]   CLASS_SHIFT     = 5'd4;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_HIT       = 3'd0,
    STATUS_MISS      = 3'd1,
    STATUS_FREED     = 3'd2,
    STATUS_TOO_LARGE = 3'd3,
    STATUS_FULL      = 3'd4
  } status_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the accepted request word
    logic judge;  // latch the lookup outcome
    logic pop;    // read the head entry of the selected class
    logic push;   // write the handle at the tail of the selected class
    logic emit;   // load the response register
  } sflm_cmd_t;

  // Lookup status from the datapath to the controller
  typedef struct packed {
    logic pop_ok;
    logic push_ok;
  } sflm_stat_t;

  // Byte size held by a class: 24 for class 0, else 1 << (idx + 4)
  function automatic logic [CB_W-1:0] class_bytes(input logic [CLASS_W-1:0] idx);
    logic [CLASS_W:0] sh;
    logic [CB_W-1:0]  bytes;
    sh = {1'b0, idx} + CLASS_SHIFT;
    if (idx == '0) begin
      bytes = MIN_CLASS_BYTES;
    end else begin
      bytes = CB_W'(1) << sh;
    end
    return bytes;
  endfunction

endpackage

FILE: src/sflm_intf.sv
// ----------------------------------------------------------------------------
// Segregated free list manager channels
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface sflm_req_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [sflm_pkg::SIZE_W-1:0]   request_size;
  logic [sflm_pkg::HANDLE_W-1:0] block_handle;
  logic [sflm_pkg::SIZE_W-1:0]   block_size;

  modport source (output valid, op, request_size, block_handle, block_size, input ready);
  modport sink   (input valid, op, request_size, block_handle, block_size, output ready);
endinterface

interface sflm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sflm_pkg::STATUS_W-1:0] status;
  logic [sflm_pkg::HANDLE_W-1:0] granted_handle;
  logic [sflm_pkg::CLASS_W-1:0]  class_index;
  logic [sflm_pkg::TOTAL_W-1:0]  free_total;

  modport source (output valid, status, granted_handle, class_index, free_total, input ready);
  modport sink   (input valid, status, granted_handle, class_index, free_total, output ready);
endinterface

FILE: src/sflm_ctrl.sv
// ----------------------------------------------------------------------------
// Segregated free list manager controller
// Sequences one request word through capture, lookup and response, and
// owns the handshake of both channels.
// ----------------------------------------------------------------------------
module sflm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  sflm_pkg::sflm_stat_t stat,
  output sflm_pkg::sflm_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // Response register can take a word when empty or being drained
  assign slot_free = !out_valid_r || out_ready;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Decode commands from the current state
  always_comb begin
    cmd       = '0;
    cmd.load  = (state_r == ST_IDLE) && in_valid;
    cmd.judge = (state_r == ST_LOOK);
    cmd.pop   = (state_r == ST_LOOK) && stat.pop_ok;
    cmd.push  = (state_r == ST_LOOK) && stat.push_ok;
    cmd.emit  = (state_r == ST_DONE) && slot_free;
  end

  // Next state and response valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and response valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: src/sflm_dpath.sv
// ----------------------------------------------------------------------------
// Segregated free list manager datapath
// Size class selection, per-class ring pointers and fill counts, the shared
// handle ring memory and the response register.
// ----------------------------------------------------------------------------
module sflm_dpath #(
  parameter int RING_DEPTH  = 256,
  parameter int NUM_CLASSES = 10,
  parameter int HANDLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sflm_pkg::sflm_cmd_t           cmd,
  output sflm_pkg::sflm_stat_t          stat,
  input  logic                          in_op,
  input  logic [sflm_pkg::SIZE_W-1:0]   in_request_size,
  input  logic [sflm_pkg::HANDLE_W-1:0] in_block_handle,
  input  logic [sflm_pkg::SIZE_W-1:0]   in_block_size,
  output logic [sflm_pkg::STATUS_W-1:0] out_status,
  output logic [sflm_pkg::HANDLE_W-1:0] out_granted_handle,
  output logic [sflm_pkg::CLASS_W-1:0]  out_class_index,
  output logic [sflm_pkg::TOTAL_W-1:0]  out_free_total
);

  localparam int SLOTS  = NUM_CLASSES * RING_DEPTH;
  localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam int CIDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TOT_W  = $clog2(SLOTS + 1);

  // Captured request
  logic                        op_r;
  logic [sflm_pkg::SIZE_W-1:0] size_r;
  logic [HANDLE_BITS-1:0]      handle_r;

  // Per-class ring bookkeeping
  logic [PTR_W-1:0]  head_r [NUM_CLASSES];
  logic [PTR_W-1:0]  tail_r [NUM_CLASSES];
  logic [FILL_W-1:0] fill_r [NUM_CLASSES];
  logic [TOT_W-1:0]  total_r;

  // Handle ring memory, one region of RING_DEPTH entries per class
  logic [HANDLE_BITS-1:0] ring_mem [SLOTS];
  logic [HANDLE_BITS-1:0] rd_data_r;

  // Lookup outcome and response register
  sflm_pkg::status_t              res_status_r, status_nxt;
  logic [sflm_pkg::CLASS_W-1:0]   res_class_r;
  sflm_pkg::status_t              out_status_r;
  logic [sflm_pkg::HANDLE_W-1:0]  out_granted_r;
  logic [sflm_pkg::CLASS_W-1:0]   out_class_r;
  logic [sflm_pkg::TOTAL_W-1:0]   out_total_r;

  logic              fits;
  logic [CIDX_W-1:0] sel;
  logic [FILL_W-1:0] sel_fill;
  logic              sel_empty;
  logic              sel_full;
  logic [PTR_W-1:0]  head_adv;
  logic [PTR_W-1:0]  tail_adv;
  logic [ADDR_W-1:0] mem_addr;

  // Pick the smallest class whose size is not below the captured size
  always_comb begin
    fits = 1'b0;
    sel  = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (sflm_pkg::CB_W'(size_r) <= sflm_pkg::class_bytes(sflm_pkg::CLASS_W'(i))) begin
        fits = 1'b1;
        sel  = CIDX_W'(i);
      end
    end
  end

  assign sel_fill  = fill_r[sel];
  assign sel_empty = (sel_fill == '0);
  assign sel_full  = (sel_fill == FILL_W'(RING_DEPTH));

  assign stat.pop_ok  = (op_r == sflm_pkg::OP_ALLOC) && fits && !sel_empty;
  assign stat.push_ok = (op_r == sflm_pkg::OP_FREE) && fits && !sel_full;

  // Advance ring pointers with wrap at the end of the ring
  assign head_adv = (head_r[sel] == PTR_W'(RING_DEPTH - 1)) ? '0 : head_r[sel] + PTR_W'(1);
  assign tail_adv = (tail_r[sel] == PTR_W'(RING_DEPTH - 1)) ? '0 : tail_r[sel] + PTR_W'(1);

  // Address the class region at the head for a pop, at the tail for a push
  assign mem_addr = ADDR_W'(sel) * ADDR_W'(RING_DEPTH)
                  + ADDR_W'(cmd.pop ? head_r[sel] : tail_r[sel]);

  // Derive the response status of the captured word
  always_comb begin
    if (op_r == sflm_pkg::OP_ALLOC) begin
      status_nxt = (fits && !sel_empty) ? sflm_pkg::STATUS_HIT : sflm_pkg::STATUS_MISS;
    end else if (!fits) begin
      status_nxt = sflm_pkg::STATUS_TOO_LARGE;
    end else if (sel_full) begin
      status_nxt = sflm_pkg::STATUS_FULL;
    end else begin
      status_nxt = sflm_pkg::STATUS_FREED;
    end
  end

  // Write pushed handles, register popped ones
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ring_mem[mem_addr] <= handle_r;
    end
    if (cmd.pop) begin
      rd_data_r <= ring_mem[mem_addr];
    end
  end

  // Update pointers, fill counts and the running total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        fill_r[i] <= '0;
      end
      total_r <= '0;
    end else begin
      if (cmd.pop) begin
        head_r[sel] <= head_adv;
        fill_r[sel] <= sel_fill - FILL_W'(1);
        total_r     <= total_r - TOT_W'(1);
      end
      if (cmd.push) begin
        tail_r[sel] <= tail_adv;
        fill_r[sel] <= sel_fill + FILL_W'(1);
        total_r     <= total_r + TOT_W'(1);
      end
    end
  end

  // Capture the request, latch the outcome, load the response
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      size_r   <= (in_op == sflm_pkg::OP_ALLOC) ? in_request_size : in_block_size;
      handle_r <= HANDLE_BITS'(in_block_handle);
    end
    if (cmd.judge) begin
      res_status_r <= status_nxt;
      res_class_r  <= fits ? sflm_pkg::CLASS_W'(sel) : '0;
    end
    if (cmd.emit) begin
      out_status_r  <= res_status_r;
      out_granted_r <= (res_status_r == sflm_pkg::STATUS_HIT)
                       ? sflm_pkg::HANDLE_W'(rd_data_r) : '0;
      out_class_r   <= res_class_r;
      out_total_r   <= sflm_pkg::TOTAL_W'(total_r);
    end
  end

  assign out_status         = out_status_r;
  assign out_granted_handle = out_granted_r;
  assign out_class_index    = out_class_r;
  assign out_free_total     = out_total_r;

  // A push adds exactly one held block
  a_push_total: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> total_r == $past(total_r) + TOT_W'(1))
    else $error("total did not grow by one after a push");

  // A pop removes exactly one held block
  a_pop_total: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> total_r == $past(total_r) - TOT_W'(1))
    else $error("total did not shrink by one after a pop");

  // Pops serve only alloc words and never coincide with a push
  a_pop_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (op_r == sflm_pkg::OP_ALLOC) && !cmd.push)
    else $error("pop issued for a free word or together with a push");

  // The selected class never holds more than one ring
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.judge |-> sel_fill <= FILL_W'(RING_DEPTH))
    else $error("class fill count beyond ring depth");

endmodule

FILE: src/segregated_free_list_manager_unit.sv
// ----------------------------------------------------------------------------
// Segregated free list manager
// Size-class free list: FIFO rings of freed block handles, one per class.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries request words. op selects alloc (request_size) or free
//   (block_handle, block_size). Every request word gives exactly one
//   response word on out_chan with status, granted_handle, class_index and
//   free_total, in request order.
//   Class 0 holds 24 bytes, class i holds 1 << (i + 4) bytes. A free files
//   the handle at the tail of the smallest fitting class; an alloc pops the
//   oldest handle of the smallest fitting class.
//   Sequencing: a word is taken in the idle state, looked up and applied to
//   the ring memory in the lookup state, and lands in the response register
//   in the done state, where out_chan.valid rises. One word is in flight at
//   a time: a new word is taken only after the last one reached the response
//   register, as the controller steps each word through capture, lookup and
//   response around the single ring memory port.
//   Reset clears all ring pointers, fill counts and the running total;
//   ring contents are not cleared and no unwritten entry is read.
//   When the receiver stalls, the response word holds in its register; the
//   next request is still taken and looked up, and waits for that register.
// ----------------------------------------------------------------------------
module segregated_free_list_manager_unit #(
  parameter int RING_DEPTH  = 256,
  parameter int NUM_CLASSES = 10,
  parameter int HANDLE_BITS = 32
) (
  input logic        clk,
  input logic        rst_n,
  sflm_req_if.sink   in_chan,
  sflm_rsp_if.source out_chan
);

  sflm_pkg::sflm_cmd_t  cmd;
  sflm_pkg::sflm_stat_t stat;

  // Sequence words and drive the handshakes
  sflm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Select classes, keep the rings and build responses
  sflm_dpath #(
    .RING_DEPTH  (RING_DEPTH),
    .NUM_CLASSES (NUM_CLASSES),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_op              (in_chan.op),
    .in_request_size    (in_chan.request_size),
    .in_block_handle    (in_chan.block_handle),
    .in_block_size      (in_chan.block_size),
    .out_status         (out_chan.status),
    .out_granted_handle (out_chan.granted_handle),
    .out_class_index    (out_chan.class_index),
    .out_free_total     (out_chan.free_total)
  );

endmodule
